// ===== sv/bdipe_pkg.sv =====
// Shared types, constants and byte tables of the IPS patch encoder.
package bdipe_pkg;

  localparam int MAX_RUN = 32;

  localparam logic [5:0]  RLE_MIN_RESET = 6'd3;
  localparam logic [24:0] OFFSET_LIMIT  = 25'h1000000;
  localparam logic [24:0] POS_SAT       = 25'h1FFFFFF;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_DIFF = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] new_byte;
    logic [7:0] base_byte;
    logic       beyond_base;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] patch_byte;
    logic       last_out;
    status_t    status;
  } out_item_t;

  // "PATCH"
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h50;
      3'd1:    c = 8'h41;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h43;
      default: c = 8'h48;
    endcase
    return c;
  endfunction

  // "EOF"
  function automatic logic [7:0] eof_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h45;
      2'd1:    c = 8'h4F;
      default: c = 8'h46;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/bdipe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bdipe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/binary_diff_ips_patch_encoder_core.sv =====
// IPS patch encoder: one new/base byte pair per item, patch stream bytes out.
//
// An item that produces no output leaves the encoder idle, and the next can be
// accepted right after it. Items that produce bytes hold the input until their
// bytes are moved into the output register, one byte per cycle while the
// output is free, for "PATCH", the record header (offset, length, RLE fields),
// the RLE value and "EOF"; literal record data is read back from the run
// buffer RAM a byte at a time, with a read state and then an output state for
// each byte. Output stalls hold the byte sequence. The run buffer needs no
// clearing after reset.
module binary_diff_ips_patch_encoder_core #(
  parameter int MAX_RUN = bdipe_pkg::MAX_RUN
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bdipe_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bdipe_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [5:0]           cfg_wdata
);

  localparam int AW = $clog2(MAX_RUN);
  localparam int LW = $clog2(MAX_RUN + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_HDR, S_OFS, S_LEN, S_RLEV, S_RD, S_DATA, S_EOF
  } state_t;

  state_t state_r;
  logic [2:0] seq_r;
  logic [AW-1:0] idx_r;

  logic [5:0] rle_min_r;
  logic hdr_sent_r;
  logic in_run_r;
  logic [24:0] pos_r;
  logic [24:0] run_start_r;
  logic [LW-1:0] run_len_r;
  logic run_uni_r;
  logic [7:0] run_first_r;
  logic any_rec_r;
  logic err_r;

  // snapshot of the record to write out
  logic [23:0] rec_start_r;
  logic [LW-1:0] rec_len_r;
  logic rec_rle_r;
  logic [7:0] rec_first_r;
  logic rec_emit_r;
  logic eof_r;
  bdipe_pkg::status_t eof_st_r;

  bdipe_pkg::out_item_t out_data_r;
  logic out_valid_r;

  logic in_fire, out_free;
  logic diff, full, flush, drop;
  logic [LW-1:0] base_len, len_inc, f_len;
  logic [24:0] u_start, f_start;
  logic u_uni, f_uni;
  logic [7:0] u_first, f_first;

  logic in_run_nxt, run_uni_nxt, any_rec_nxt, err_nxt, rle_nxt;
  logic [LW-1:0] run_len_nxt;
  logic [24:0] pos_nxt, run_start_nxt;
  logic [7:0] run_first_nxt;
  bdipe_pkg::status_t eof_st_nxt;

  logic emit_en, emit_last;
  logic [7:0] emit_byte;
  bdipe_pkg::status_t emit_st;
  logic [15:0] len16;
  logic len_done, data_done;
  state_t tail;

  logic ram_we, ram_re;
  logic [7:0] ram_rdata;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // per-item run update
  always_comb begin
    diff     = in_data.beyond_base || (in_data.new_byte != in_data.base_byte);
    base_len = in_run_r ? run_len_r : '0;
    len_inc  = base_len + LW'(1);
    full     = (len_inc == LW'(MAX_RUN));
    u_start  = in_run_r ? run_start_r : pos_r;
    u_uni    = in_run_r ? (run_uni_r && (run_first_r == in_data.new_byte)) : 1'b1;
    u_first  = in_run_r ? run_first_r : in_data.new_byte;

    if (diff) begin
      f_start = u_start;
      f_len   = len_inc;
      f_uni   = u_uni;
      f_first = u_first;
      flush   = full || in_data.last_in;
    end else begin
      f_start = run_start_r;
      f_len   = run_len_r;
      f_uni   = run_uni_r;
      f_first = run_first_r;
      flush   = in_run_r;
    end

    drop    = (f_start >= bdipe_pkg::OFFSET_LIMIT);
    rle_nxt = f_uni && (6'(f_len) >= rle_min_r);

    in_run_nxt    = in_run_r;
    run_len_nxt   = run_len_r;
    run_uni_nxt   = run_uni_r;
    run_first_nxt = run_first_r;
    run_start_nxt = run_start_r;
    if (diff) begin
      run_start_nxt = u_start;
      run_first_nxt = u_first;
    end
    if (flush || in_data.last_in) begin
      in_run_nxt  = 1'b0;
      run_len_nxt = '0;
      run_uni_nxt = 1'b1;
    end else if (diff) begin
      in_run_nxt  = 1'b1;
      run_len_nxt = len_inc;
      run_uni_nxt = u_uni;
    end

    err_nxt     = err_r || (flush && drop);
    any_rec_nxt = any_rec_r || (flush && !drop);
    if (err_nxt) begin
      eof_st_nxt = bdipe_pkg::ST_DROPPED;
    end else if (any_rec_nxt) begin
      eof_st_nxt = bdipe_pkg::ST_OK;
    end else begin
      eof_st_nxt = bdipe_pkg::ST_NO_DIFF;
    end

    if (in_data.last_in) begin
      pos_nxt = '0;
    end else if (pos_r == bdipe_pkg::POS_SAT) begin
      pos_nxt = pos_r;
    end else begin
      pos_nxt = pos_r + 25'd1;
    end
  end

  assign ram_we = in_fire && diff;
  assign ram_re = (state_r == S_RD);

  bdipe_ram #(
    .WIDTH (8),
    .DEPTH (MAX_RUN)
  ) u_run_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (base_len[AW-1:0]),
    .wdata (in_data.new_byte),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // byte selection for the output register
  always_comb begin
    len16     = 16'(rec_len_r);
    tail      = eof_r ? S_EOF : S_IDLE;
    len_done  = rec_rle_r ? (seq_r == 3'd3) : (seq_r == 3'd1);
    data_done = (LW'(idx_r) + LW'(1) == rec_len_r);
    emit_en   = 1'b0;
    emit_byte = '0;
    emit_last = 1'b0;
    emit_st   = bdipe_pkg::ST_OK;
    unique case (state_r)
      S_HDR: begin
        emit_en   = out_free;
        emit_byte = bdipe_pkg::hdr_char(seq_r);
      end
      S_OFS: begin
        emit_en = out_free;
        if (seq_r == 3'd0) begin
          emit_byte = rec_start_r[23:16];
        end else if (seq_r == 3'd1) begin
          emit_byte = rec_start_r[15:8];
        end else begin
          emit_byte = rec_start_r[7:0];
        end
      end
      S_LEN: begin
        emit_en = out_free;
        // RLE records carry a zero size field before the run length
        if (rec_rle_r) begin
          if (seq_r == 3'd2) begin
            emit_byte = len16[15:8];
          end else if (seq_r == 3'd3) begin
            emit_byte = len16[7:0];
          end
        end else begin
          emit_byte = (seq_r == 3'd0) ? len16[15:8] : len16[7:0];
        end
      end
      S_RLEV: begin
        emit_en   = out_free;
        emit_byte = rec_first_r;
      end
      S_DATA: begin
        emit_en   = out_free;
        emit_byte = ram_rdata;
      end
      S_EOF: begin
        emit_en   = out_free;
        emit_byte = bdipe_pkg::eof_char(seq_r[1:0]);
        emit_last = (seq_r == 3'd2);
        emit_st   = eof_st_r;
      end
      S_IDLE, S_RD: begin
        emit_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seq_r       <= '0;
      idx_r       <= '0;
      rle_min_r   <= bdipe_pkg::RLE_MIN_RESET;
      hdr_sent_r  <= 1'b0;
      in_run_r    <= 1'b0;
      pos_r       <= '0;
      run_start_r <= '0;
      run_len_r   <= '0;
      run_uni_r   <= 1'b1;
      any_rec_r   <= 1'b0;
      err_r       <= 1'b0;
      rec_emit_r  <= 1'b0;
      eof_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        rle_min_r <= cfg_wdata;
      end

      if (emit_en) begin
        out_valid_r           <= 1'b1;
        out_data_r.patch_byte <= emit_byte;
        out_data_r.last_out   <= emit_last;
        out_data_r.status     <= emit_st;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            in_run_r    <= in_run_nxt;
            run_len_r   <= run_len_nxt;
            run_uni_r   <= run_uni_nxt;
            run_first_r <= run_first_nxt;
            run_start_r <= in_data.last_in ? '0 : run_start_nxt;
            pos_r       <= pos_nxt;
            hdr_sent_r  <= !in_data.last_in;
            any_rec_r   <= in_data.last_in ? 1'b0 : any_rec_nxt;
            err_r       <= in_data.last_in ? 1'b0 : err_nxt;
            rec_start_r <= f_start[23:0];
            rec_len_r   <= f_len;
            rec_rle_r   <= rle_nxt;
            rec_first_r <= f_first;
            rec_emit_r  <= flush && !drop;
            eof_r       <= in_data.last_in;
            eof_st_r    <= eof_st_nxt;
            seq_r       <= '0;
            if (!hdr_sent_r) begin
              state_r <= S_HDR;
            end else if (flush && !drop) begin
              state_r <= S_OFS;
            end else if (in_data.last_in) begin
              state_r <= S_EOF;
            end
          end
        end
        S_HDR: begin
          if (out_free) begin
            if (seq_r == 3'd4) begin
              seq_r   <= '0;
              state_r <= rec_emit_r ? S_OFS : tail;
            end else begin
              seq_r <= seq_r + 3'd1;
            end
          end
        end
        S_OFS: begin
          if (out_free) begin
            if (seq_r == 3'd2) begin
              seq_r   <= '0;
              state_r <= S_LEN;
            end else begin
              seq_r <= seq_r + 3'd1;
            end
          end
        end
        S_LEN: begin
          if (out_free) begin
            if (len_done) begin
              seq_r   <= '0;
              idx_r   <= '0;
              state_r <= rec_rle_r ? S_RLEV : S_RD;
            end else begin
              seq_r <= seq_r + 3'd1;
            end
          end
        end
        S_RLEV: begin
          if (out_free) begin
            state_r <= tail;
          end
        end
        S_RD: begin
          state_r <= S_DATA;
        end
        S_DATA: begin
          if (out_free) begin
            if (data_done) begin
              state_r <= tail;
            end else begin
              idx_r   <= idx_r + AW'(1);
              state_r <= S_RD;
            end
          end
        end
        S_EOF: begin
          if (out_free) begin
            if (seq_r == 3'd2) begin
              seq_r   <= '0;
              state_r <= S_IDLE;
            end else begin
              seq_r <= seq_r + 3'd1;
            end
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a new patch always starts with its header
  a_hdr_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !hdr_sent_r |=> state_r == S_HDR)
    else $error("header not started for first item of a patch");

  // an open run is never empty and never reaches the buffer depth
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_run_r |-> (run_len_r != '0) && (run_len_r < LW'(MAX_RUN)))
    else $error("open run length out of range");

  // literal data reads stay inside the buffered record
  a_data_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_DATA) |-> (LW'(idx_r) < rec_len_r))
    else $error("record data index beyond run length");

  // the final patch byte is the F of EOF and only EOF carries nonzero status
  a_last_f: assert property (@(posedge clk) disable iff (!rst_n)
    emit_en && emit_last |-> state_r == S_EOF && emit_byte == 8'h46)
    else $error("last byte is not the end of EOF");

  a_status_eof: assert property (@(posedge clk) disable iff (!rst_n)
    emit_en && emit_st != bdipe_pkg::ST_OK |-> state_r == S_EOF)
    else $error("nonzero status outside EOF");
`endif

endmodule
